>>> design/humidity_temp_frame_check_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the humidity/temperature frame checker
// ----------------------------------------------------------------------------
`ifndef HUMIDITY_TEMP_FRAME_CHECK_UNIT_ASSERT_SVH
`define HUMIDITY_TEMP_FRAME_CHECK_UNIT_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define HFC_ASSERT_NOW(lbl, clk_s, rstn_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
		else $error("frame check assertion failed");

// next-cycle implication, disabled while reset is asserted
`define HFC_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
		else $error("frame check assertion failed");

`endif

>>> design/hfc_pkg.sv
// ----------------------------------------------------------------------------
// hfc_pkg
// Shared constants, types and the CRC-8 step for the frame checker.
// ----------------------------------------------------------------------------
`default_nettype none

package hfc_pkg;

	localparam logic [7:0] CRC_INIT = 8'hFF;
	localparam logic [7:0] CRC_POLY = 8'h31;

	// byte positions within a six-byte response
	localparam logic [2:0] POS_T_HI  = 3'd0;
	localparam logic [2:0] POS_T_LO  = 3'd1;
	localparam logic [2:0] POS_T_CRC = 3'd2;
	localparam logic [2:0] POS_H_HI  = 3'd3;
	localparam logic [2:0] POS_H_LO  = 3'd4;
	localparam logic [2:0] POS_H_CRC = 3'd5;

	localparam logic [14:0]        TEMP_SPAN   = 15'd17500;
	localparam logic signed [15:0] TEMP_OFFSET = -16'sd4500;
	localparam logic [13:0]        HUM_SPAN    = 14'd10000;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic [15:0] temp_word;
		logic [15:0] hum_word;
		logic        temp_ok;
		logic        hum_ok;
	} frame_rec_t;

	typedef struct packed {
		logic       push;
		frame_rec_t rec;
	} q_push_t;

	typedef struct packed {
		logic       valid;
		frame_rec_t rec;
	} q_head_t;

	// one byte through the CRC, MSB first
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

>>> design/humidity_temp_frame_check_unit.sv
// ----------------------------------------------------------------------------
// humidity_temp_frame_check_unit
// Checks a six-byte temperature/humidity response and converts it to
// hundredths of a degree and of a percent.
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  in      | in_valid/in_stall  | byte_value, frame_start
//  out     | out_valid/out_stall| temperature_centi, humidity_centi, temperature_ok,
//          |                    | humidity_ok, raw_temperature, raw_humidity
//
//  One byte is taken every cycle while in_stall is low; the CRC step and word
//  assembly sit in the front. The sixth byte of a frame is written into the queue,
//  and its result word is then loaded through the multiply into the output register.
//  A two-entry queue parts front and back; in_stall rises only when it is full.
//  arst_n clears position, CRC, flags, queue and output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module humidity_temp_frame_check_unit (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic [7:0]    byte_value,
	input  wire logic          frame_start,
	input  wire logic          in_valid,
	output logic               in_stall,
	output logic signed [14:0] temperature_centi,
	output logic [13:0]        humidity_centi,
	output logic               temperature_ok,
	output logic               humidity_ok,
	output logic [15:0]        raw_temperature,
	output logic [15:0]        raw_humidity,
	output logic               out_valid,
	input  wire logic          out_stall
);

	hfc_pkg::q_push_t q_push;
	hfc_pkg::q_head_t q_head;
	logic             q_full;
	logic             q_pop;

	hfc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_value (byte_value),
		.frame_start(frame_start),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.q_full     (q_full),
		.q_push     (q_push)
	);

	hfc_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.q_push(q_push),
		.q_full(q_full),
		.q_pop (q_pop),
		.q_head(q_head)
	);

	hfc_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.q_head           (q_head),
		.q_pop            (q_pop),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.temperature_centi(temperature_centi),
		.humidity_centi   (humidity_centi),
		.temperature_ok   (temperature_ok),
		.humidity_ok      (humidity_ok),
		.raw_temperature  (raw_temperature),
		.raw_humidity     (raw_humidity)
	);

endmodule

`default_nettype wire

>>> design/hfc_front.sv
// ----------------------------------------------------------------------------
// hfc_front
// Accepts response bytes, assembles the words and checks both CRCs.
// ----------------------------------------------------------------------------
`default_nettype none

module hfc_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic [7:0]      byte_value,
	input  wire logic            frame_start,
	input  wire logic            in_valid,
	output logic                 in_stall,
	input  wire logic            q_full,
	output hfc_pkg::q_push_t     q_push
);

	logic [2:0]  pos_q;
	logic [7:0]  crc_q;
	logic [15:0] temp_word_q;
	logic [15:0] hum_word_q;
	logic        temp_good_q;

	logic [2:0]  pos;
	logic [7:0]  crc_base;
	logic [7:0]  crc_next;
	logic [2:0]  pos_next;
	logic        take;

	assign in_stall = q_full;
	assign take     = in_valid && !in_stall;

	always_comb begin
		pos = frame_start ? hfc_pkg::POS_T_HI : pos_q;
		if (pos > hfc_pkg::POS_H_CRC) begin
			pos = hfc_pkg::POS_T_HI;
		end
		crc_base = (pos == hfc_pkg::POS_T_HI || pos == hfc_pkg::POS_H_HI) ?
			hfc_pkg::CRC_INIT : crc_q;
		crc_next = hfc_pkg::crc8_byte(crc_base, byte_value);
		pos_next = (pos == hfc_pkg::POS_H_CRC) ? hfc_pkg::POS_T_HI : pos + 3'd1;
	end

	always_comb begin
		q_push.push          = take && (pos == hfc_pkg::POS_H_CRC);
		q_push.rec.temp_word = temp_word_q;
		q_push.rec.hum_word  = hum_word_q;
		q_push.rec.temp_ok   = temp_good_q;
		q_push.rec.hum_ok    = (crc_base == byte_value);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= hfc_pkg::POS_T_HI;
			crc_q       <= hfc_pkg::CRC_INIT;
			temp_word_q <= '0;
			hum_word_q  <= '0;
			temp_good_q <= 1'b0;
		end else if (take) begin
			pos_q <= pos_next;
			case (pos)
				hfc_pkg::POS_T_HI: begin
					temp_word_q[15:8] <= byte_value;
					crc_q             <= crc_next;
				end
				hfc_pkg::POS_T_LO: begin
					temp_word_q[7:0] <= byte_value;
					crc_q            <= crc_next;
				end
				hfc_pkg::POS_T_CRC: begin
					temp_good_q <= (crc_base == byte_value);
					crc_q       <= hfc_pkg::CRC_INIT;
				end
				hfc_pkg::POS_H_HI: begin
					hum_word_q[15:8] <= byte_value;
					crc_q            <= crc_next;
				end
				hfc_pkg::POS_H_LO: begin
					hum_word_q[7:0] <= byte_value;
					crc_q           <= crc_next;
				end
				default: begin
					crc_q <= hfc_pkg::CRC_INIT;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

>>> design/hfc_queue.sv
// ----------------------------------------------------------------------------
// hfc_queue
// Short queue of checked frames between the front and the back part.
// ----------------------------------------------------------------------------
`default_nettype none

module hfc_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire hfc_pkg::q_push_t q_push,
	output logic                  q_full,
	input  wire logic             q_pop,
	output hfc_pkg::q_head_t      q_head
);

	hfc_pkg::frame_rec_t                slot_q [hfc_pkg::QDEPTH];
	logic [hfc_pkg::QPTR_W-1:0]         wr_ptr_q;
	logic [hfc_pkg::QPTR_W-1:0]         rd_ptr_q;
	logic [hfc_pkg::QCNT_W-1:0]         count_q;
	logic                               do_push;
	logic                               do_pop;

	assign q_full       = (count_q == hfc_pkg::QCNT_W'(hfc_pkg::QDEPTH));
	assign q_head.valid = (count_q != '0);
	assign q_head.rec   = slot_q[rd_ptr_q];
	assign do_push      = q_push.push && !q_full;
	assign do_pop       = q_pop && q_head.valid;

	function automatic logic [hfc_pkg::QPTR_W-1:0] ptr_inc(
		input logic [hfc_pkg::QPTR_W-1:0] p
	);
		return (p == hfc_pkg::QPTR_W'(hfc_pkg::QDEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= q_push.rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

>>> design/hfc_back.sv
// ----------------------------------------------------------------------------
// hfc_back
// Scales checked words to fixed point and holds the result word.
// ----------------------------------------------------------------------------
`default_nettype none

module hfc_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire hfc_pkg::q_head_t   q_head,
	output logic                    q_pop,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [14:0]      temperature_centi,
	output logic [13:0]             humidity_centi,
	output logic                    temperature_ok,
	output logic                    humidity_ok,
	output logic [15:0]             raw_temperature,
	output logic [15:0]             raw_humidity
);

	logic               out_valid_q;
	logic signed [14:0] temp_q;
	logic [13:0]        hum_q;
	logic               temp_ok_q;
	logic               hum_ok_q;
	logic [15:0]        raw_t_q;
	logic [15:0]        raw_h_q;

	logic [30:0]        t_prod;
	logic [29:0]        h_prod;
	logic signed [15:0] t_sum;

	// load a new word whenever the output register is free or being taken
	assign q_pop = q_head.valid && (!out_valid_q || !out_stall);

	always_comb begin
		t_prod = 31'(hfc_pkg::TEMP_SPAN) * 31'(q_head.rec.temp_word);
		h_prod = 30'(hfc_pkg::HUM_SPAN) * 30'(q_head.rec.hum_word);
		t_sum  = $signed({1'b0, t_prod[30:16]}) + hfc_pkg::TEMP_OFFSET;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (q_pop) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			temp_q    <= q_head.rec.temp_ok ? t_sum[14:0] : '0;
			hum_q     <= q_head.rec.hum_ok ? h_prod[29:16] : '0;
			temp_ok_q <= q_head.rec.temp_ok;
			hum_ok_q  <= q_head.rec.hum_ok;
			raw_t_q   <= q_head.rec.temp_word;
			raw_h_q   <= q_head.rec.hum_word;
		end
	end

	assign out_valid         = out_valid_q;
	assign temperature_centi = temp_q;
	assign humidity_centi    = hum_q;
	assign temperature_ok    = temp_ok_q;
	assign humidity_ok       = hum_ok_q;
	assign raw_temperature   = raw_t_q;
	assign raw_humidity      = raw_h_q;

endmodule

`default_nettype wire

>>> design/hfc_checker.sv
// ----------------------------------------------------------------------------
// hfc_checker
// Port-level checks on the frame checker's result channel.
// ----------------------------------------------------------------------------
`default_nettype none

`include "humidity_temp_frame_check_unit_assert.svh"

module hfc_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               out_valid,
	input wire logic               out_stall,
	input wire logic signed [14:0] temperature_centi,
	input wire logic [13:0]        humidity_centi,
	input wire logic               temperature_ok,
	input wire logic               humidity_ok,
	input wire logic [15:0]        raw_temperature,
	input wire logic [15:0]        raw_humidity
);

	`HFC_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(temperature_centi) && $stable(humidity_centi) && $stable(raw_temperature) && $stable(raw_humidity) && $stable(temperature_ok) && $stable(humidity_ok))
	`HFC_ASSERT_NOW(a_fail_zero, clk, arst_n, out_valid, (temperature_ok || temperature_centi == 15'sd0) && (humidity_ok || humidity_centi == 14'd0))
	`HFC_ASSERT_NOW(a_temp_range, clk, arst_n, out_valid && temperature_ok, temperature_centi >= -15'sd4500 && temperature_centi <= 15'sd12999)
	`HFC_ASSERT_NOW(a_hum_range, clk, arst_n, out_valid && humidity_ok, humidity_centi <= 14'd9999)

endmodule

bind humidity_temp_frame_check_unit hfc_checker u_hfc_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.out_valid        (out_valid),
	.out_stall        (out_stall),
	.temperature_centi(temperature_centi),
	.humidity_centi   (humidity_centi),
	.temperature_ok   (temperature_ok),
	.humidity_ok      (humidity_ok),
	.raw_temperature  (raw_temperature),
	.raw_humidity     (raw_humidity)
);

`default_nettype wire
